>>> design/osr_pkg.sv
// Shared types and codes for the oldest stale record recycler.
package osr_pkg;

	localparam int unsigned OSR_TABLE_SLOTS = 64;
	localparam int unsigned STEP_W = 32;
	localparam int unsigned KIND_W = 4;
	localparam int unsigned MASK_W = 16;
	localparam int unsigned CFG_W = 32;

	// transaction operation codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_RECYCLE = 1'b1;

	// result status codes
	localparam logic [1:0] ST_WRITTEN = 2'd0;
	localparam logic [1:0] ST_RECYCLED = 2'd1;
	localparam logic [1:0] ST_NONE = 2'd2;

	// configuration register indexes
	localparam logic CFG_RETAIN = 1'b0;
	localparam logic CFG_KIND_MASK = 1'b1;

	// one table entry as held in the record memory
	typedef struct packed {
		logic in_use;
		logic [KIND_W-1:0] kind;
		logic has_step;
		logic [STEP_W-1:0] step;
	} entry_t;

endpackage

>>> design/osr_ram.sv
// Generic simple dual-port RAM with a registered read.
module osr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> design/osr_scan.sv
// Candidate test and running minimum over the entries read during a scan.
module osr_scan #(
	parameter int unsigned TABLE_SLOTS = osr_pkg::OSR_TABLE_SLOTS
) (
	input logic clk,
	input logic arst_n,
	input logic clear,
	input logic vld,
	input logic [$clog2(TABLE_SLOTS)-1:0] idx,
	input osr_pkg::entry_t entry,
	input logic [osr_pkg::STEP_W-1:0] retain,
	input logic [osr_pkg::MASK_W-1:0] kind_mask,
	input logic [osr_pkg::STEP_W-1:0] req_step,
	output logic found,
	output logic [$clog2(TABLE_SLOTS)-1:0] best_idx,
	output logic [osr_pkg::STEP_W-1:0] best_step
);
	import osr_pkg::*;

	localparam int unsigned AW = $clog2(TABLE_SLOTS);

	logic found_q;
	logic [AW-1:0] best_idx_q;
	logic [STEP_W-1:0] best_step_q;
	logic [STEP_W:0] reach;
	logic cand;
	logic take;

	// step plus window at one extra bit, so the sum never wraps
	assign reach = {1'b0, entry.step} + {1'b0, retain};
	assign cand = entry.in_use && kind_mask[entry.kind] && entry.has_step
		&& (reach < {1'b0, req_step});
	// strict less-than keeps the lowest slot on a tie
	assign take = vld && cand && (!found_q || (entry.step < best_step_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (clear) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_idx_q <= idx;
			best_step_q <= entry.step;
		end
	end

	assign found = found_q;
	assign best_idx = best_idx_q;
	assign best_step = best_step_q;

	a_found_holds: assert property (@(posedge clk) disable iff (!arst_n)
		$past(found_q) && !$past(clear) |-> found_q)
		else $error("scan lost its candidate without a clear");

	a_min_falls: assert property (@(posedge clk) disable iff (!arst_n)
		found_q && $past(found_q) && !$past(clear) |-> best_step_q <= $past(best_step_q))
		else $error("best step grew during a scan");

	a_take_cand: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> found_q && best_idx_q == $past(idx))
		else $error("accepted candidate not recorded");

endmodule

>>> design/oldest_stale_record_recycler_top.sv
// Top level of the oldest stale record recycler: control, configuration and result.
module oldest_stale_record_recycler_top #(
	parameter int unsigned TABLE_SLOTS = osr_pkg::OSR_TABLE_SLOTS
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic operation,
	input logic [5:0] slot_index,
	input logic slot_in_use,
	input logic [osr_pkg::KIND_W-1:0] slot_kind,
	input logic slot_has_step,
	input logic [osr_pkg::STEP_W-1:0] slot_step,
	input logic request_has_step,
	input logic [osr_pkg::STEP_W-1:0] request_step,
	output logic done,
	output logic [1:0] status,
	output logic [5:0] victim_index,
	output logic [osr_pkg::STEP_W-1:0] victim_step,
	input logic cfg_we,
	input logic cfg_index,
	input logic [osr_pkg::CFG_W-1:0] cfg_data
);
	import osr_pkg::*;

	// A transaction is taken at a rising edge where start is high and busy is low.
	// Every transaction gives exactly one result, shown for one cycle with done high;
	// the receiver cannot stall it, so capture it on that cycle. A slot write, a
	// recycle request without a step, or one whose step does not exceed the retain
	// window, answers in the cycle after the accepting edge and busy stays low.
	// A recycle request that needs a search reads the record memory one slot per
	// cycle, then drains the last read (S_LAST) and clears the victim slot, if one
	// was found (S_FIN), before the result is shown. busy is high throughout and
	// falls on the cycle the result is shown, so the next transaction may be taken
	// on that edge. After reset the block clears every slot of the record memory,
	// with busy high; configuration writes are taken at any time, but should only
	// be made while no transaction is outstanding.

	localparam int unsigned AW = $clog2(TABLE_SLOTS);
	localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_SLOTS - 1);

	localparam logic [2:0] S_INIT = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_LAST = 3'd3;
	localparam logic [2:0] S_FIN = 3'd4;

	logic [2:0] state_q;
	logic [AW-1:0] cnt_q;
	logic [STEP_W-1:0] retain_q;
	logic [MASK_W-1:0] kind_mask_q;
	logic [STEP_W-1:0] req_step_q;
	logic rd_vld_s1;
	logic [AW-1:0] rd_idx_s1;

	logic done_q;
	logic [1:0] status_q;
	logic [5:0] victim_index_q;
	logic [STEP_W-1:0] victim_step_q;

	logic accept;
	logic in_range;
	logic req_ok;
	logic scan_go;
	logic [AW+5:0] slot_wide;
	logic [AW+5:0] victim_wide;

	logic ram_we;
	logic [AW-1:0] ram_waddr;
	entry_t ram_wdata;
	entry_t ram_rdata;
	entry_t slot_entry;

	logic found;
	logic [AW-1:0] best_idx;
	logic [STEP_W-1:0] best_step;

	assign busy = (state_q != S_IDLE);
	assign accept = start && !busy;

	// slots at or beyond the table are dropped
	assign in_range = 32'(slot_index) < 32'(TABLE_SLOTS);
	assign slot_wide = (AW+6)'(slot_index);
	assign victim_wide = (AW+6)'(best_idx);
	assign req_ok = request_has_step && (request_step > retain_q);
	assign scan_go = accept && (operation == OP_RECYCLE) && req_ok;

	assign slot_entry.in_use = slot_in_use;
	assign slot_entry.kind = slot_kind;
	assign slot_entry.has_step = slot_has_step;
	assign slot_entry.step = slot_step;

	// one write port: clearing pass, slot load or victim clear
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = cnt_q;
		ram_wdata = '0;
		case (state_q)
			S_INIT: begin
				ram_we = 1'b1;
			end
			S_IDLE: begin
				ram_we = accept && (operation == OP_WRITE) && in_range;
				ram_waddr = slot_wide[AW-1:0];
				ram_wdata = slot_entry;
			end
			S_FIN: begin
				ram_we = found;
				ram_waddr = best_idx;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	osr_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(TABLE_SLOTS)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(cnt_q),
		.rdata(ram_rdata)
	);

	osr_scan #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.clear(scan_go),
		.vld(rd_vld_s1),
		.idx(rd_idx_s1),
		.entry(ram_rdata),
		.retain(retain_q),
		.kind_mask(kind_mask_q),
		.req_step(req_step_q),
		.found(found),
		.best_idx(best_idx),
		.best_step(best_step)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retain_q <= '0;
			kind_mask_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RETAIN: retain_q <= cfg_data[STEP_W-1:0];
				CFG_KIND_MASK: kind_mask_q <= cfg_data[MASK_W-1:0];
				default: retain_q <= retain_q;
			endcase
		end
	end

	// sequencer: clearing pass, idle, scan reads, drain, finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			cnt_q <= '0;
			rd_vld_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == S_SCAN);
			done_q <= 1'b0;
			case (state_q)
				S_INIT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_SLOT) begin
						cnt_q <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						done_q <= !scan_go;
						cnt_q <= '0;
						if (scan_go) begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_SLOT) begin
						cnt_q <= '0;
						state_q <= S_LAST;
					end
				end
				S_LAST: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// read tag, request step and result payload
	always_ff @(posedge clk) begin
		rd_idx_s1 <= cnt_q;
		if (scan_go) begin
			req_step_q <= request_step;
		end
		if (accept && !scan_go) begin
			status_q <= (operation == OP_WRITE) ? ST_WRITTEN : ST_NONE;
			victim_index_q <= '0;
			victim_step_q <= '0;
		end else if (state_q == S_FIN) begin
			status_q <= found ? ST_RECYCLED : ST_NONE;
			victim_index_q <= found ? victim_wide[5:0] : 6'd0;
			victim_step_q <= found ? best_step : '0;
		end
	end

	assign done = done_q;
	assign status = status_q;
	assign victim_index = victim_index_q;
	assign victim_step = victim_step_q;

	a_fin_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN |=> done && state_q == S_IDLE)
		else $error("finish did not give a result");

	a_zero_victim: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_RECYCLED |-> victim_index == 6'd0 && victim_step == '0)
		else $error("victim fields set without a recycle");

	a_scan_start: assert property (@(posedge clk) disable iff (!arst_n)
		scan_go |=> state_q == S_SCAN && cnt_q == '0 && !done)
		else $error("search did not start from slot zero");

	a_drain_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LAST |-> rd_vld_s1 && rd_idx_s1 == LAST_SLOT)
		else $error("last slot read missing at drain");

endmodule

>>> verif/tb_oldest_stale_record_recycler_top.sv
// Testbench for the oldest stale record recycler: directed and random transactions, predicted and checked.
module tb_oldest_stale_record_recycler_top;
	import osr_pkg::*;

	localparam int unsigned PHASES = 8;
	localparam int unsigned ITEMS_PER_PHASE = 150;
	// Pause before a register write once the table has gone quiet, and the tail at the end.
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned TAIL_CYCLES = 100;

	// One input transaction as presented on the request ports.
	typedef struct {
		logic op;
		logic [5:0] slot_index;
		logic slot_in_use;
		logic [KIND_W-1:0] slot_kind;
		logic slot_has_step;
		logic [STEP_W-1:0] slot_step;
		logic request_has_step;
		logic [STEP_W-1:0] request_step;
	} item_t;

	// One result transaction as seen on the result ports.
	typedef struct {
		logic [1:0] status;
		logic [5:0] victim_index;
		logic [STEP_W-1:0] victim_step;
	} result_t;

	// Scoreboard: keeps its own copy of the record table and the two registers, and queues
	// the outcome that each accepted transaction must produce.
	class recycle_board;
		entry_t slots [OSR_TABLE_SLOTS];
		logic [STEP_W-1:0] retain;
		logic [MASK_W-1:0] kind_mask;
		result_t due_results [$];
		int errors;

		function new();
			foreach (slots[s]) slots[s] = '0;
			retain = '0;
			kind_mask = '0;
			errors = 0;
		endfunction

		function void set_register(logic idx, logic [CFG_W-1:0] value);
			if (idx == CFG_RETAIN) retain = value[STEP_W-1:0];
			else kind_mask = value[MASK_W-1:0];
		endfunction

		// Apply one transaction to the table copy and return what the block must report.
		function result_t predict_outcome(item_t it);
			result_t res;
			logic found;
			int unsigned best;
			logic [STEP_W:0] reach;
			res = '{ST_NONE, '0, '0};
			if (it.op == OP_WRITE) begin
				if (it.slot_index < OSR_TABLE_SLOTS)
					slots[it.slot_index] = '{it.slot_in_use, it.slot_kind, it.slot_has_step,
						it.slot_step};
				res.status = ST_WRITTEN;
			end else if (it.request_has_step && it.request_step > retain) begin
				found = 1'b0;
				best = 0;
				for (int s = 0; s < OSR_TABLE_SLOTS; s++) begin
					// widen by one bit so that step plus window never wraps
					reach = {1'b0, slots[s].step} + {1'b0, retain};
					if (slots[s].in_use && kind_mask[slots[s].kind] && slots[s].has_step
						&& reach < {1'b0, it.request_step}
						&& (!found || slots[s].step < slots[best].step)) begin
						found = 1'b1;
						best = s;
					end
				end
				if (found) begin
					res = '{ST_RECYCLED, best[5:0], slots[best].step};
					slots[best] = '0;
				end
			end
			return res;
		endfunction

		function void note_item(item_t it);
			due_results.push_back(predict_outcome(it));
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (due_results.size() == 0) begin
				$error("result with no transaction outstanding: status %0d index %0d step %0h",
					got.status, got.victim_index, got.victim_step);
				errors++;
				return;
			end
			want = due_results.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				errors++;
			end
			if (got.victim_index !== want.victim_index) begin
				$error("victim_index: expected %0d, got %0d", want.victim_index, got.victim_index);
				errors++;
			end
			if (got.victim_step !== want.victim_step) begin
				$error("victim_step: expected %0h, got %0h", want.victim_step, got.victim_step);
				errors++;
			end
		endfunction

		function int pending();
			return due_results.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic operation = OP_WRITE;
	logic [5:0] slot_index = '0;
	logic slot_in_use = 1'b0;
	logic [KIND_W-1:0] slot_kind = '0;
	logic slot_has_step = 1'b0;
	logic [STEP_W-1:0] slot_step = '0;
	logic request_has_step = 1'b0;
	logic [STEP_W-1:0] request_step = '0;
	logic done;
	logic [1:0] status;
	logic [5:0] victim_index;
	logic [STEP_W-1:0] victim_step;
	logic cfg_we = 1'b0;
	logic cfg_index = CFG_RETAIN;
	logic [CFG_W-1:0] cfg_data = '0;

	recycle_board board;

	oldest_stale_record_recycler_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.slot_index(slot_index),
		.slot_in_use(slot_in_use),
		.slot_kind(slot_kind),
		.slot_has_step(slot_has_step),
		.slot_step(slot_step),
		.request_has_step(request_has_step),
		.request_step(request_step),
		.done(done),
		.status(status),
		.victim_index(victim_index),
		.victim_step(victim_step),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result monitor: capture the ports at the edge that ends the strobe cycle, then check a
	// little later so that the driver has noted any transaction accepted at the same edge.
	always begin
		result_t seen;
		@(posedge clk);
		if (arst_n && done === 1'b1) begin
			seen = '{status, victim_index, victim_step};
			#1;
			board.check_result(seen);
		end
	end

	// Write both registers back to back; keep the enable high across the pair so it is
	// assigned only once per edge. Put junk above the mask so the block must drop it.
	task automatic write_settings(logic [STEP_W-1:0] retain_val, logic [MASK_W-1:0] mask_val);
		logic [CFG_W-1:0] mask_word;
		mask_word = $urandom;
		mask_word[MASK_W-1:0] = mask_val;
		cfg_we <= 1'b1;
		cfg_index <= CFG_RETAIN;
		cfg_data <= retain_val;
		@(posedge clk);
		board.set_register(CFG_RETAIN, retain_val);
		cfg_index <= CFG_KIND_MASK;
		cfg_data <= mask_word;
		@(posedge clk);
		board.set_register(CFG_KIND_MASK, mask_word);
		cfg_we <= 1'b0;
	endtask

	// Present one transaction after an optional gap and hold it until the block takes it.
	// With no gap, start stays high straight from the previous transaction.
	task automatic drive_item(item_t it, int unsigned gap);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		operation <= it.op;
		slot_index <= it.slot_index;
		slot_in_use <= it.slot_in_use;
		slot_kind <= it.slot_kind;
		slot_has_step <= it.slot_has_step;
		slot_step <= it.slot_step;
		request_has_step <= it.request_has_step;
		request_step <= it.request_step;
		do @(posedge clk); while (busy !== 1'b0);
		board.note_item(it);
	endtask

	// Drop start and wait until every outstanding result has come back.
	task automatic settle();
		start <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly back to back or short gaps, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(99, 0);
		if (roll < 55) return 0;
		if (roll < 90) return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	// Directed write; the recycle-only fields carry junk that the block must ignore.
	function automatic item_t write_item(logic [5:0] slot, logic in_use, logic [KIND_W-1:0] kind,
		logic has_step, logic [STEP_W-1:0] step);
		item_t it;
		it = '{OP_WRITE, slot, in_use, kind, has_step, step, 1'($urandom_range(1, 0)), $urandom};
		return it;
	endfunction

	// Directed recycle request; the write-only fields carry junk.
	function automatic item_t recycle_item(logic has_step, logic [STEP_W-1:0] step);
		item_t it;
		it = '{OP_RECYCLE, 6'($urandom_range(63, 0)), 1'($urandom_range(1, 0)),
			4'($urandom_range(15, 0)), 1'($urandom_range(1, 0)), $urandom, has_step, step};
		return it;
	endfunction

	// Random transaction. Most steps cluster round the phase anchor so that requests land
	// just above or just below the window of the stored records; the rest span the full range.
	function automatic item_t random_item(logic [STEP_W-1:0] anchor, logic [STEP_W-1:0] retain_val);
		item_t it;
		logic [63:0] near_req;
		it.op = ($urandom_range(99, 0) < 60) ? OP_WRITE : OP_RECYCLE;
		it.slot_index = 6'($urandom_range(63, 0));
		it.slot_in_use = ($urandom_range(99, 0) < 85);
		it.slot_kind = 4'($urandom_range(15, 0));
		it.slot_has_step = ($urandom_range(99, 0) < 85);
		it.slot_step = ($urandom_range(99, 0) < 75) ? anchor + $urandom_range(127, 0) : $urandom;
		near_req = 64'(anchor) + 64'(retain_val) + 64'($urandom_range(255, 0));
		it.request_has_step = ($urandom_range(99, 0) < 90);
		it.request_step = ($urandom_range(99, 0) < 80) ? near_req[STEP_W-1:0] : $urandom;
		return it;
	endfunction

	initial begin
		item_t directed [$];
		logic [STEP_W-1:0] retain_val;
		logic [MASK_W-1:0] mask_val;
		logic [STEP_W-1:0] headroom;
		logic [STEP_W-1:0] anchor;
		int unsigned calm_left;
		int unsigned gap;
		board = new();
		calm_left = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: window of ten, every kind recyclable bar fifteen.
		write_settings(32'd10, 16'h7FFF);
		directed.push_back(recycle_item(1'b1, '1));                 // empty table
		directed.push_back(write_item(6'd0, 1'b1, 4'd0, 1'b1, 32'd100));
		directed.push_back(write_item(6'd63, 1'b1, 4'd15, 1'b1, 32'd0)); // kind masked off
		directed.push_back(write_item(6'd5, 1'b1, 4'd3, 1'b0, 32'd1));   // no step
		directed.push_back(write_item(6'd7, 1'b0, 4'd1, 1'b1, 32'd2));   // not in use
		directed.push_back(write_item(6'd9, 1'b1, 4'd2, 1'b1, 32'd100)); // ties with slot 0
		directed.push_back(write_item(6'd10, 1'b1, 4'd4, 1'b1, '1));     // step plus window wraps
		directed.push_back(recycle_item(1'b0, '1));                 // request without a step
		directed.push_back(recycle_item(1'b1, 32'd10));             // request not above window
		directed.push_back(recycle_item(1'b1, 32'd0));
		directed.push_back(recycle_item(1'b1, 32'd110));            // exactly on the boundary
		directed.push_back(recycle_item(1'b1, 32'd111));            // tie: lowest slot first
		directed.push_back(recycle_item(1'b1, 32'd111));
		directed.push_back(recycle_item(1'b1, '1));                 // nothing eligible left
		directed.push_back(write_item(6'd63, 1'b1, 4'd14, 1'b1, 32'd0));
		directed.push_back(recycle_item(1'b1, '1));
		directed.push_back(write_item(6'd1, 1'b1, 4'd15, 1'b1, '1));
		directed.push_back(write_item(6'd2, 1'b1, 4'd1, 1'b1, 32'd0));
		directed.push_back(recycle_item(1'b1, 32'd11));             // first step above window
		directed.push_back(recycle_item(1'b1, '1));
		foreach (directed[i]) drive_item(directed[i], pick_gap());
		settle();

		// Random phases, each under its own register setting, extremes first.
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					retain_val = '0;
					mask_val = '1;
				end
				1: begin
					retain_val = '1;
					mask_val = '1;
				end
				2: begin
					retain_val = '0;
					mask_val = '0;
				end
				3: begin
					retain_val = 32'hFFFF_FFF0;
					mask_val = '1;
				end
				default: begin
					retain_val = $urandom_range(1, 0) ? $urandom_range(1000, 0) : $urandom;
					mask_val = 16'($urandom);
				end
			endcase
			write_settings(retain_val, mask_val);
			headroom = '1 - retain_val;
			anchor = (headroom > 300) ? $urandom_range(headroom - 300, 0) : '0;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// now and then run a stretch with no idling at all
				if (calm_left == 0 && $urandom_range(19, 0) == 0)
					calm_left = $urandom_range(60, 20);
				if (calm_left != 0) begin
					gap = 0;
					calm_left--;
				end else begin
					gap = pick_gap();
				end
				drive_item(random_item(anchor, retain_val), gap);
			end
			settle();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.errors == 0) begin
			$display("PASS oldest_stale_record_recycler_top");
		end else begin
			$display("FAIL oldest_stale_record_recycler_top");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#6_000_000;
		$display("FAIL oldest_stale_record_recycler_top");
		$finish;
	end

endmodule
